/* src/isingmet_pkg.sv */
// Package for the Metropolis spin update unit: item kinds, register indexes,
// site selection codes and the command/status structs between controller and datapath.
// No dependencies.
package isingmet_pkg;

    // Widths fixed by the item and register fields.
    localparam int unsigned COORD_W   = 8;
    localparam int unsigned DRAW_W    = 8;
    localparam int unsigned CFG_W     = 9;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned ENERGY_W  = 5;

    // Item kinds. The unused code behaves as a read.
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_ATTEMPT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FOUR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EIGHT = 2'd2;

    // Reset value of the side register.
    localparam logic [CFG_W-1:0] SIDE_RESET = 9'd256;

    // Which lattice site the memory port addresses.
    typedef enum logic [2:0] {
        SITE_CENTER,
        SITE_ROW_NEXT,
        SITE_ROW_PREV,
        SITE_COL_PREV,
        SITE_COL_NEXT
    } t_site;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;    // latch the accepted item
        logic  rd_en;   // read the lattice at the selected site
        t_site site;    // site addressed by the memory port
        logic  finish;  // write back and load the result register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       bad;   // a coordinate is at or above the side in use
        logic [1:0] kind;  // kind of the item in work
    } t_dp_status;

endpackage

/* src/isingmet_ctrl.sv */
// Controller for the Metropolis spin update unit: sequences lattice reads,
// the write-back and the result handshake. Depends on isingmet_pkg.
module isingmet_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    input  isingmet_pkg::t_dp_status i_status,
    output isingmet_pkg::t_ctrl_cmd  o_cmd
);
    import isingmet_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_NBR,
        S_WAIT,
        S_FINISH
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_nbr_cnt, n_nbr_cnt;
    logic       r_out_valid, n_out_valid;
    logic       can_finish;
    t_site      nbr_site;

    // The result register is free when empty or being taken this cycle.
    assign can_finish = !r_out_valid || i_ready;

    // Neighbor visited at each step of the neighbor reads.
    always_comb begin
        case (r_nbr_cnt)
            2'd0:    nbr_site = SITE_ROW_NEXT;
            2'd1:    nbr_site = SITE_ROW_PREV;
            2'd2:    nbr_site = SITE_COL_PREV;
            default: nbr_site = SITE_COL_NEXT;
        endcase
    end

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        n_nbr_cnt    = r_nbr_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        o_cmd.load   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.site   = SITE_CENTER;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_nbr_cnt = 2'd0;
                if (i_status.bad || i_status.kind == KIND_WRITE) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = (i_status.kind == KIND_ATTEMPT) ? S_NBR : S_WAIT;
                end
            end
            S_NBR: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.site  = nbr_site;
                n_nbr_cnt   = r_nbr_cnt + 2'd1;
                if (r_nbr_cnt == 2'd3) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (can_finish) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nbr_cnt   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nbr_cnt   <= n_nbr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

/* src/isingmet_dpath.sv */
// Datapath for the Metropolis spin update unit: configuration registers,
// the single-port lattice memory, neighbor addressing and the acceptance test.
// Depends on isingmet_pkg.
module isingmet_dpath #(
    parameter int unsigned MAX_SIDE = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [isingmet_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [isingmet_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [1:0]                            i_kind,
    input  logic [isingmet_pkg::COORD_W-1:0]      i_col,
    input  logic [isingmet_pkg::COORD_W-1:0]      i_row,
    input  logic                                  i_spin_in,
    input  logic [isingmet_pkg::DRAW_W-1:0]       i_draw,
    input  isingmet_pkg::t_ctrl_cmd               i_cmd,
    output isingmet_pkg::t_dp_status              o_status,
    output logic                                  o_spin_out,
    output logic                                  o_flipped,
    output logic signed [isingmet_pkg::ENERGY_W-1:0] o_energy_change,
    output logic                                  o_bad_site
);
    import isingmet_pkg::*;

    localparam int unsigned DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int unsigned AW       = $clog2(DEPTH);
    localparam int unsigned SIDE_MAX = (1 << CFG_W) - 1;
    localparam int unsigned SIDE_CAP = (MAX_SIDE > SIDE_MAX) ? SIDE_MAX : MAX_SIDE;

    // Configuration registers.
    logic [CFG_W-1:0] r_side, r_lim_four, r_lim_eight;

    // Item in work.
    logic [1:0]         r_kind;
    logic [CFG_W-1:0]   r_col, r_row;
    logic               r_spin_in;
    logic [DRAW_W-1:0]  r_draw;

    // Lattice memory and captured spins.
    logic               mem [DEPTH];
    logic               r_rdata;
    logic               r_cap_vld;
    t_site              r_cap_site;
    logic               r_center;
    logic [3:0]         r_nbr;

    // Result register.
    logic                       r_spin_out, r_flipped, r_bad_site;
    logic signed [ENERGY_W-1:0] r_energy;

    logic [CFG_W-1:0]   side_use;
    logic               bad;
    logic [CFG_W-1:0]   row_next, row_prev, col_next, col_prev;
    logic [CFG_W-1:0]   sel_col, sel_row;
    logic [AW-1:0]      addr;
    logic [2:0]         n_agree;
    logic signed [ENERGY_W-1:0] energy;
    logic               accept;
    logic               we;
    logic               wdata;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SIDE_RESET;
            r_lim_four  <= '0;
            r_lim_eight <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIDE:        r_side      <= i_cfg_data;
                CFG_LIMIT_FOUR:  r_lim_four  <= i_cfg_data;
                CFG_LIMIT_EIGHT: r_lim_eight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latch the accepted item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_col     <= CFG_W'(i_col);
            r_row     <= CFG_W'(i_row);
            r_spin_in <= i_spin_in;
            r_draw    <= i_draw;
        end
    end

    // Side in use saturates at the lattice size; a coordinate at or beyond it is bad.
    assign side_use = (r_side > CFG_W'(SIDE_CAP)) ? CFG_W'(SIDE_CAP) : r_side;
    assign bad      = (r_col >= side_use) || (r_row >= side_use);

    assign o_status.bad  = bad;
    assign o_status.kind = r_kind;

    // Wrapped neighbor coordinates; valid only for a good site.
    assign row_next = (r_row + CFG_W'(1) == side_use) ? '0 : r_row + CFG_W'(1);
    assign row_prev = (r_row == '0) ? side_use - CFG_W'(1) : r_row - CFG_W'(1);
    assign col_next = (r_col + CFG_W'(1) == side_use) ? '0 : r_col + CFG_W'(1);
    assign col_prev = (r_col == '0) ? side_use - CFG_W'(1) : r_col - CFG_W'(1);

    // Site selection for the memory port.
    always_comb begin
        unique case (i_cmd.site)
            SITE_CENTER:   begin sel_col = r_col;    sel_row = r_row;    end
            SITE_ROW_NEXT: begin sel_col = r_col;    sel_row = row_next; end
            SITE_ROW_PREV: begin sel_col = r_col;    sel_row = row_prev; end
            SITE_COL_PREV: begin sel_col = col_prev; sel_row = r_row;    end
            SITE_COL_NEXT: begin sel_col = col_next; sel_row = r_row;    end
            default:       begin sel_col = r_col;    sel_row = r_row;    end
        endcase
    end

    // Column-major address; for a good site the true value stays below DEPTH.
    assign addr = AW'(sel_col) * AW'(MAX_SIDE) + AW'(sel_row);

    // Energy change: dE = 4 * (number of neighbors equal to the site) - 8.
    assign n_agree = 3'($countones(~(r_nbr ^ {4{r_center}})));

    always_comb begin
        case (n_agree)
            3'd0:    energy = -5'sd8;
            3'd1:    energy = -5'sd4;
            3'd2:    energy = 5'sd0;
            3'd3:    energy = 5'sd4;
            default: energy = 5'sd8;
        endcase
    end

    // Metropolis acceptance on integer thresholds.
    always_comb begin
        case (n_agree)
            3'd3:    accept = ({1'b0, r_draw} < r_lim_four);
            3'd4:    accept = ({1'b0, r_draw} < r_lim_eight);
            default: accept = 1'b1;
        endcase
    end

    // Write-back: a stored spin, or the flipped site after an accepted attempt.
    assign we    = i_cmd.finish && !bad &&
                   ((r_kind == KIND_WRITE) || ((r_kind == KIND_ATTEMPT) && accept));
    assign wdata = (r_kind == KIND_WRITE) ? r_spin_in : ~r_center;

    // Single-port lattice memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else if (i_cmd.rd_en) begin
            r_rdata <= mem[addr];
        end
    end

    // Track which site the read data belongs to.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_vld <= 1'b0;
        end else begin
            r_cap_vld <= i_cmd.rd_en;
        end
        r_cap_site <= i_cmd.site;
    end

    // Capture the site and neighbor spins.
    always_ff @(posedge i_clk) begin
        if (r_cap_vld) begin
            case (r_cap_site)
                SITE_CENTER:   r_center <= r_rdata;
                SITE_ROW_NEXT: r_nbr[0] <= r_rdata;
                SITE_ROW_PREV: r_nbr[1] <= r_rdata;
                SITE_COL_PREV: r_nbr[2] <= r_rdata;
                SITE_COL_NEXT: r_nbr[3] <= r_rdata;
                default: ;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (bad) begin
                r_spin_out <= 1'b0;
                r_flipped  <= 1'b0;
                r_energy   <= '0;
                r_bad_site <= 1'b1;
            end else begin
                r_bad_site <= 1'b0;
                case (r_kind)
                    KIND_WRITE: begin
                        r_spin_out <= r_spin_in;
                        r_flipped  <= 1'b0;
                        r_energy   <= '0;
                    end
                    KIND_ATTEMPT: begin
                        r_spin_out <= accept ? ~r_center : r_center;
                        r_flipped  <= accept;
                        r_energy   <= energy;
                    end
                    default: begin
                        r_spin_out <= r_center;
                        r_flipped  <= 1'b0;
                        r_energy   <= '0;
                    end
                endcase
            end
        end
    end

    assign o_spin_out      = r_spin_out;
    assign o_flipped       = r_flipped;
    assign o_energy_change = r_energy;
    assign o_bad_site      = r_bad_site;

endmodule

/* src/ising_metropolis_spin_update_unit.sv */
// Top level of the Metropolis spin update unit on a toroidal lattice.
// Depends on isingmet_pkg, isingmet_ctrl and isingmet_dpath.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_ready         i_kind i_col i_row i_spin_in i_draw
//  result    out        o_valid / i_ready         o_spin_out o_flipped o_energy_change o_bad_site
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// One item at a time. From the accepting edge to a result in the output register, an
// attempt reads the site and then its four neighbors, waits for the last capture and
// finishes; a read reads the site, waits and finishes; a write or a bad site goes straight
// to the final step. The unit then returns to idle before it takes the next item. Reads go
// one by one through the single lattice port, then the read data and capture registers.
// A new item is taken while the previous result still waits to be taken.
// A result stalled at the output holds the unit in its final step.
// Reset is synchronous; the lattice holds no defined value until written.
module ising_metropolis_spin_update_unit #(
    parameter int unsigned MAX_SIDE = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_kind,
    input  logic [isingmet_pkg::COORD_W-1:0]      i_col,
    input  logic [isingmet_pkg::COORD_W-1:0]      i_row,
    input  logic                                  i_spin_in,
    input  logic [isingmet_pkg::DRAW_W-1:0]       i_draw,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_spin_out,
    output logic                                  o_flipped,
    output logic signed [isingmet_pkg::ENERGY_W-1:0] o_energy_change,
    output logic                                  o_bad_site,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [isingmet_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [isingmet_pkg::CFG_W-1:0]        i_cfg_data
);
    import isingmet_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    isingmet_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    isingmet_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_spin_in       (i_spin_in),
        .i_draw          (i_draw),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_spin_out      (o_spin_out),
        .o_flipped       (o_flipped),
        .o_energy_change (o_energy_change),
        .o_bad_site      (o_bad_site)
    );

endmodule

/* src/isingmet_checker.sv */
// Port-level checks for the Metropolis spin update unit, bound to the top level.
// Depends on isingmet_pkg and ising_metropolis_spin_update_unit.
module isingmet_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic                                  o_flipped,
    input logic                                  o_spin_out,
    input logic signed [isingmet_pkg::ENERGY_W-1:0] o_energy_change,
    input logic                                  o_bad_site
);
    import isingmet_pkg::*;

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    // One item at a time: no second item right after an accepted one.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after an accepted item");

    // A bad site reports nothing else.
    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_site |-> !o_flipped && !o_spin_out && o_energy_change == 5'sd0)
        else $error("bad site result carries data");

    // Only the five possible energy changes appear.
    a_energy_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_energy_change == -5'sd8 || o_energy_change == -5'sd4 ||
                     o_energy_change == 5'sd0 || o_energy_change == 5'sd4 ||
                     o_energy_change == 5'sd8))
        else $error("impossible energy change");

    // A move that lowers the energy is always taken.
    a_downhill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_energy_change == -5'sd4 || o_energy_change == -5'sd8) |-> o_flipped)
        else $error("downhill move not taken");

endmodule

bind ising_metropolis_spin_update_unit isingmet_checker u_isingmet_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_flipped       (o_flipped),
    .o_spin_out      (o_spin_out),
    .o_energy_change (o_energy_change),
    .o_bad_site      (o_bad_site)
);
